### design/kca_pkg.sv
package kca_pkg;

    // Field widths
    localparam int unsigned PeriodW   = 16;
    localparam int unsigned CompareW  = 15;
    localparam int unsigned CountW    = 4;
    localparam int unsigned DebW      = 12;
    localparam int unsigned KeyW      = 2;
    localparam int unsigned OpW       = 2;
    localparam int unsigned InDataW   = 8;
    localparam int unsigned OutDataW  = 40;
    localparam int unsigned ApbDataW  = 32;

    // Register reset values and debounce counter saturation value
    localparam logic [PeriodW-1:0] AlarmPeriodRst   = 16'd15291;
    localparam logic [DebW-1:0]    DebounceLimitRst = 12'd2048;
    localparam logic [DebW-1:0]    DebounceMax      = '1;

    // Register indexes (paddr bit 2)
    localparam logic RegAlarmPeriod   = 1'b0;
    localparam logic RegDebounceLimit = 1'b1;

    typedef enum logic [OpW-1:0] {
        OP_KEY    = 2'd0,
        OP_TICK   = 2'd1,
        OP_BUTTON = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // Keypad start count, row-major
    function automatic logic [CountW-1:0] key_count(input logic [KeyW-1:0] row,
                                                    input logic [KeyW-1:0] col);
        logic [CountW-1:0] v;
        unique case ({row, col})
            4'h0: v = 4'd1;
            4'h1: v = 4'd2;
            4'h2: v = 4'd3;
            4'h3: v = 4'd10;
            4'h4: v = 4'd4;
            4'h5: v = 4'd5;
            4'h6: v = 4'd6;
            4'h7: v = 4'd11;
            4'h8: v = 4'd7;
            4'h9: v = 4'd8;
            4'ha: v = 4'd9;
            4'hb: v = 4'd12;
            4'hc: v = 4'd15;
            4'hd: v = 4'd0;
            4'he: v = 4'd14;
            default: v = 4'd13;
        endcase
        return v;
    endfunction

endpackage

### design/keypad_countdown_alarm_top.sv
// The result of an input transaction is registered and shown on the master side in the next cycle.
// Throughput: one item per cycle unless the master side stalls; the single output
// register frees in the same cycle it is taken, so s_axis_tready = !valid || m_axis_tready.
// Reset: synchronous active low; countdown, debouncer and period clear,
// alarm_period returns to 15291 and debounce_limit to 2048.
module keypad_countdown_alarm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] key_row, [3:2] key_column, [4] button_level, [7:5] zero
    input  logic [kca_pkg::InDataW-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [kca_pkg::OpW-1:0]       s_axis_tuser,
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] pitch_period, [30:16] compare_value, [31] pitch_update,
    // [32] counting_flag, [36:33] remaining_count, [37] silence_press, [39:38] zero
    output logic [kca_pkg::OutDataW-1:0]  m_axis_tdata,
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:2]                    paddr,
    input  logic [kca_pkg::ApbDataW-1:0]  pwdata,
    output logic [kca_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);
    import kca_pkg::*;

    // config registers
    logic [PeriodW-1:0] r_alarm_period;
    logic [DebW-1:0]    r_debounce_limit;

    // block state
    logic [CountW-1:0]  r_remaining,   n_remaining;
    logic               r_running,     n_running;
    logic [PeriodW-1:0] r_period,      n_period;
    logic [DebW-1:0]    r_low_samples, n_low_samples;
    logic               r_latched,     n_latched;

    // result register
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                n_update, n_silence;

    logic    in_xact;
    t_opcode op;
    logic [KeyW-1:0]   key_row, key_col;
    logic              btn_level;
    logic [CountW-1:0] key_val, rem_dec;

    assign pready = 1'b1;

    // config write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_period   <= AlarmPeriodRst;
            r_debounce_limit <= DebounceLimitRst;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == RegAlarmPeriod) begin
                r_alarm_period <= pwdata[PeriodW-1:0];
            end else begin
                r_debounce_limit <= pwdata[DebW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == RegDebounceLimit) begin
            prdata = {{(ApbDataW-DebW){1'b0}}, r_debounce_limit};
        end else begin
            prdata = {{(ApbDataW-PeriodW){1'b0}}, r_alarm_period};
        end
    end

    // input unpack
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign op        = t_opcode'(s_axis_tuser);
    assign key_row   = s_axis_tdata[1:0];
    assign key_col   = s_axis_tdata[3:2];
    assign btn_level = s_axis_tdata[4];
    assign key_val   = key_count(key_row, key_col);
    assign rem_dec   = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;

    // next state for one item
    always_comb begin
        n_remaining   = r_remaining;
        n_running     = r_running;
        n_period      = r_period;
        n_low_samples = r_low_samples;
        n_latched     = r_latched;
        n_update      = 1'b0;
        n_silence     = 1'b0;
        unique case (op)
            OP_KEY: begin
                if (!r_running && key_val != '0) begin
                    n_running   = 1'b1;
                    n_remaining = key_val;
                end
            end
            OP_TICK: begin
                if (r_running) begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_running = 1'b0;
                        n_period  = r_alarm_period;
                        n_update  = (r_alarm_period != r_period);
                    end
                end
            end
            OP_BUTTON: begin
                if (!r_running) begin
                    if (btn_level) begin
                        // released: debouncer restarts
                        n_latched     = 1'b0;
                        n_low_samples = '0;
                    end else if (r_low_samples > r_debounce_limit) begin
                        if (!r_latched) begin
                            // accepted press silences the buzzer
                            n_latched     = 1'b1;
                            n_low_samples = '0;
                            n_silence     = 1'b1;
                            n_period      = '0;
                            n_update      = (r_period != '0);
                        end else begin
                            n_low_samples = {{(DebW-1){1'b0}}, 1'b1};
                        end
                    end else if (r_low_samples != DebounceMax) begin
                        n_low_samples = r_low_samples + 1'b1;
                    end
                end
            end
            default: begin
                // no effect, report state
            end
        endcase
    end

    // state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining   <= '0;
            r_running     <= 1'b0;
            r_period      <= '0;
            r_low_samples <= '0;
            r_latched     <= 1'b0;
        end else if (in_xact) begin
            r_remaining   <= n_remaining;
            r_running     <= n_running;
            r_period      <= n_period;
            r_low_samples <= n_low_samples;
            r_latched     <= n_latched;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_out_data <= {2'b00,
                           n_silence,
                           n_running ? n_remaining : {CountW{1'b0}},
                           n_running,
                           n_update,
                           n_period[PeriodW-1:1],
                           n_period};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### design/kca_checker.sv
module kca_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [kca_pkg::OutDataW-1:0]  m_axis_tdata
);
    import kca_pkg::*;

    // compare is always half the period
    a_compare_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:16] == m_axis_tdata[15:1])
        else $error("compare_value is not half of pitch_period");

    // idle results report no remaining count
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |-> m_axis_tdata[36:33] == '0)
        else $error("remaining_count nonzero while idle");

    // a silencing press leaves the buzzer off and the countdown stopped
    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[37]) |->
            (m_axis_tdata[15:0] == '0 && !m_axis_tdata[32]))
        else $error("silence_press with buzzer on or countdown running");

    // period only changes when the countdown has stopped
    a_update_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> !m_axis_tdata[32])
        else $error("pitch_update while countdown running");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind keypad_countdown_alarm_top kca_checker u_kca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
